[rtl/bsc_pkg.sv]
// bsc_pkg: shared types and constants for the bounded utf-8 string copy block
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package bsc_pkg;

    // default parameter values
    localparam int DEF_MAX_BUFFER = 65536;
    localparam int DEF_LANES      = 8;

    // hard lane ceiling set by the 64-bit word
    localparam int MAX_LANES = 8;
    localparam int LIDX_W    = 4;   // holds a lane number or a lane count up to 8

    // fixed field widths
    localparam int WORD_W  = 64;
    localparam int BE_W    = 8;
    localparam int INDEX_W = 13;
    localparam int COUNT_W = 16;
    localparam int SIZE_W  = 17;
    localparam int CFG_IDX_W = 2;
    localparam int TAIL_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UTF8_MODE   = 2'd1;

    // configuration reset values
    localparam logic [SIZE_W-1:0] BUFFER_SIZE_RST = 17'd65536;
    localparam logic              UTF8_MODE_RST   = 1'b1;

    // continuation counter saturates here; expected tails never exceed 3
    localparam logic [TAIL_W-1:0] TAIL_SAT = 3'd4;

    // per-lane classification of one byte
    typedef struct packed {
        logic              nul;       // byte is a terminator
        logic              lim;       // byte position reached the limit
        logic              lead;      // byte is not a continuation byte
        logic [1:0]        exp_tail;  // continuation bytes a lead expects
    } t_lane;

    // merged view of one word
    typedef struct packed {
        logic              stop;
        logic              cut;
        logic [BE_W-1:0]   be;
        logic [BE_W-1:0]   keep;
        logic [LIDX_W-1:0] stop_lane;
        logic [LIDX_W-1:0] nchar;
        logic              lead_any;
        logic [LIDX_W-1:0] lead_lane;
        logic [1:0]        lead_exp;
        logic [LIDX_W-1:0] tail;
    } t_merge;

    // results caused by one input beat
    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic [WORD_W-1:0]  data;
        logic [BE_W-1:0]    be;
        logic               done;
        logic [COUNT_W-1:0] bytes;
        logic [COUNT_W-1:0] chars;
        logic               second;
        logic [INDEX_W-1:0] idx2;
        logic [BE_W-1:0]    be2;
    } t_item;

endpackage

[rtl/bsc_lane.sv]
// bsc_lane: classifies one source byte (terminator, limit hit, utf-8 lead)
// depends on bsc_pkg
`timescale 1ns / 1ps

module bsc_lane #(
    parameter int LANE_IDX = 0
) (
    input  logic [7:0]                  i_byte,
    input  logic [bsc_pkg::LIDX_W-1:0]  i_room,
    output bsc_pkg::t_lane              o_info
);
    import bsc_pkg::*;

    localparam logic [LIDX_W-1:0] MY_LANE = LIDX_W'(LANE_IDX);

    // continuation bytes that a lead byte announces
    function automatic logic [1:0] tail_expected(input logic [7:0] b);
        logic [1:0] t;
        if (b[7:6] != 2'b11) begin
            t = 2'd0;
        end else if (b[7:5] != 3'b111) begin
            t = 2'd1;
        end else if (b[7:3] == 5'h1E) begin
            t = 2'd3;
        end else begin
            t = 2'd2;
        end
        return t;
    endfunction

    // classification
    always_comb begin
        o_info.nul      = (i_byte == 8'h00);
        o_info.lim      = (MY_LANE >= i_room);
        o_info.lead     = (i_byte[7:6] != 2'b10);
        o_info.exp_tail = tail_expected(i_byte);
    end

endmodule

[rtl/bsc_merge.sv]
// bsc_merge: combines lane results into stop point, masks, counts and last lead
// depends on bsc_pkg
`timescale 1ns / 1ps

module bsc_merge #(
    parameter int NLANES = 8
) (
    input  bsc_pkg::t_lane  i_lane [NLANES],
    output bsc_pkg::t_merge o_merge
);
    import bsc_pkg::*;

    // priority scan from the lowest lane
    always_comb begin
        logic stopped;
        stopped = 1'b0;
        o_merge = '0;
        for (int k = 0; k < NLANES; k++) begin
            if (!stopped) begin
                o_merge.be[k] = 1'b1;
                if (i_lane[k].nul || i_lane[k].lim) begin
                    stopped           = 1'b1;
                    o_merge.stop      = 1'b1;
                    o_merge.stop_lane = LIDX_W'(k);
                    o_merge.cut       = !i_lane[k].nul;
                end else begin
                    o_merge.keep[k] = 1'b1;
                    if (i_lane[k].lead) begin
                        o_merge.nchar     = o_merge.nchar + LIDX_W'(1);
                        o_merge.lead_any  = 1'b1;
                        o_merge.lead_lane = LIDX_W'(k);
                        o_merge.lead_exp  = i_lane[k].exp_tail;
                        o_merge.tail      = '0;
                    end else begin
                        o_merge.tail = o_merge.tail + LIDX_W'(1);
                    end
                end
            end
        end
    end

endmodule

[rtl/bsc_outq.sv]
// bsc_outq: two-entry result queue, splits an item into one or two output beats
// depends on bsc_pkg
`timescale 1ns / 1ps

module bsc_outq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  bsc_pkg::t_item              i_item,
    output logic                        o_full,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bsc_pkg::INDEX_W-1:0] o_word_index,
    output logic [bsc_pkg::WORD_W-1:0]  o_word_data,
    output logic [bsc_pkg::BE_W-1:0]    o_byte_enable,
    output logic                        o_copy_done,
    output logic [bsc_pkg::COUNT_W-1:0] o_byte_count,
    output logic [bsc_pkg::COUNT_W-1:0] o_char_count,
    output logic                        o_last
);
    import bsc_pkg::*;

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        r_phase;
    t_item       w_head;
    logic        w_beat;
    logic        w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign w_head  = r_mem[r_rd_ptr];
    assign w_beat  = o_valid && i_ready;
    assign w_pop   = w_beat && (!w_head.second || r_phase);

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers, fill count and beat phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_phase  <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, w_pop};
            if (w_beat) begin
                r_phase <= !w_pop;
            end
        end
    end

    // output beat select: the main write or the trim nul write
    always_comb begin
        o_copy_done  = w_head.done;
        o_byte_count = w_head.bytes;
        o_char_count = w_head.chars;
        if (r_phase) begin
            o_word_index  = w_head.idx2;
            o_word_data   = '0;
            o_byte_enable = w_head.be2;
            o_last        = 1'b1;
        end else begin
            o_word_index  = w_head.idx;
            o_word_data   = w_head.data;
            o_byte_enable = w_head.be;
            o_last        = !w_head.second;
        end
    end

endmodule

[rtl/bounded_utf8_string_copy_top.sv]
// bounded_utf8_string_copy_top: one 64-bit source word per beat, lane classify,
// merge, running string state and trim logic; results leave through bsc_outq.
// the result of an accepted beat before the string end is registered in bsc_outq.
// throughput: one input beat per cycle while bsc_outq is not full; a word that
// trims an earlier word's lead sends two output beats via the queue's one port.
// reset (synchronous, active low) clears string state and the queue, and loads
// buffer_size 65536 and utf8_mode 1.
`timescale 1ns / 1ps

module bounded_utf8_string_copy_top #(
    parameter int MAX_BUFFER = bsc_pkg::DEF_MAX_BUFFER,
    parameter int LANES      = bsc_pkg::DEF_LANES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bsc_pkg::SIZE_W-1:0]    i_cfg_data,
    // source word channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bsc_pkg::WORD_W-1:0]    i_source_word,
    input  logic                          i_first_word,
    // destination write channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bsc_pkg::INDEX_W-1:0]   o_word_index,
    output logic [bsc_pkg::WORD_W-1:0]    o_word_data,
    output logic [bsc_pkg::BE_W-1:0]      o_byte_enable,
    output logic                          o_copy_done,
    output logic [bsc_pkg::COUNT_W-1:0]   o_byte_count,
    output logic [bsc_pkg::COUNT_W-1:0]   o_char_count,
    output logic                          o_last
);
    import bsc_pkg::*;

    localparam int NLANES = (LANES > MAX_LANES) ? MAX_LANES : LANES;
    localparam int POS_RAW = $clog2(MAX_BUFFER + MAX_LANES + 1);
    localparam int POS_W = (POS_RAW > SIZE_W) ? POS_RAW : SIZE_W;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_BUFFER);
    localparam logic [POS_W-1:0] LANE_STEP = POS_W'(NLANES);

    // configuration registers
    logic [SIZE_W-1:0]  r_buffer_size;
    logic               r_utf8_mode;

    // string state
    logic [POS_W-1:0]   r_word_pos,   n_word_pos;
    logic [POS_W-1:0]   r_base,       n_base;
    logic [COUNT_W-1:0] r_chars,      n_chars;
    logic [POS_W-1:0]   r_lead_pos,   n_lead_pos;
    logic [POS_W-1:0]   r_lead_word,  n_lead_word;
    logic [LIDX_W-1:0]  r_lead_lane,  n_lead_lane;
    logic [1:0]         r_lead_exp,   n_lead_exp;
    logic [TAIL_W-1:0]  r_tail,       n_tail;
    logic               r_lead_valid, n_lead_valid;
    logic               r_finished,   n_finished;

    // state as seen by the current beat (a first word starts from zero)
    logic [POS_W-1:0]   w_word_pos, w_base, w_lead_pos, w_lead_word;
    logic [COUNT_W-1:0] w_chars;
    logic [LIDX_W-1:0]  w_lead_lane;
    logic [1:0]         w_lead_exp;
    logic [TAIL_W-1:0]  w_tail;
    logic               w_lead_valid, w_finished;

    logic [POS_W-1:0]   w_size, w_limit, w_diff;
    logic [LIDX_W-1:0]  w_room;
    t_lane              w_lane [NLANES];
    t_merge             w_merge;
    logic               w_accept, w_push, w_full, w_trim;
    logic [LIDX_W:0]    w_tail_sum;
    logic [BE_W-1:0]    w_keep, w_lead_hot;
    logic [WORD_W-1:0]  w_data;
    logic [POS_W-1:0]   w_bytes;
    t_item              w_item;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !w_full;
    assign w_accept    = i_valid && o_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= BUFFER_SIZE_RST;
            r_utf8_mode   <= UTF8_MODE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BUFFER_SIZE: r_buffer_size <= i_cfg_data;
                REG_UTF8_MODE:   r_utf8_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective state for this beat
    always_comb begin
        if (i_first_word) begin
            w_word_pos   = '0;
            w_base       = '0;
            w_chars      = '0;
            w_lead_pos   = '0;
            w_lead_word  = '0;
            w_lead_lane  = '0;
            w_lead_exp   = '0;
            w_tail       = '0;
            w_lead_valid = 1'b0;
            w_finished   = 1'b0;
        end else begin
            w_word_pos   = r_word_pos;
            w_base       = r_base;
            w_chars      = r_chars;
            w_lead_pos   = r_lead_pos;
            w_lead_word  = r_lead_word;
            w_lead_lane  = r_lead_lane;
            w_lead_exp   = r_lead_exp;
            w_tail       = r_tail;
            w_lead_valid = r_lead_valid;
            w_finished   = r_finished;
        end
    end

    // limit and room left in this word
    always_comb begin
        w_size = POS_W'(r_buffer_size);
        if (r_buffer_size == '0) begin
            w_size = POS_W'(1);
        end else if (w_size > MAX_POS) begin
            w_size = MAX_POS;
        end
        w_limit = w_size - POS_W'(1);
        w_diff  = (w_limit > w_base) ? (w_limit - w_base) : '0;
        w_room  = (w_diff >= LANE_STEP) ? LIDX_W'(NLANES) : w_diff[LIDX_W-1:0];
    end

    // byte lanes
    for (genvar g = 0; g < NLANES; g++) begin : g_lane
        bsc_lane #(
            .LANE_IDX (g)
        ) u_lane (
            .i_byte (i_source_word[8*g +: 8]),
            .i_room (w_room),
            .o_info (w_lane[g])
        );
    end

    // lane merge
    bsc_merge #(
        .NLANES (NLANES)
    ) u_merge (
        .i_lane  (w_lane),
        .o_merge (w_merge)
    );

    // running state update, trim decision and result build
    always_comb begin
        n_word_pos   = r_word_pos;
        n_base       = r_base;
        n_chars      = r_chars;
        n_lead_pos   = r_lead_pos;
        n_lead_word  = r_lead_word;
        n_lead_lane  = r_lead_lane;
        n_lead_exp   = r_lead_exp;
        n_tail       = r_tail;
        n_lead_valid = r_lead_valid;
        n_finished   = r_finished;

        w_push = w_accept && !w_finished;

        // lead tracking across words
        if (w_merge.lead_any) begin
            n_lead_valid = 1'b1;
            n_lead_word  = w_word_pos;
            n_lead_lane  = w_merge.lead_lane;
            n_lead_pos   = w_base + POS_W'(w_merge.lead_lane);
            n_lead_exp   = w_merge.lead_exp;
            w_tail_sum   = {1'b0, w_merge.tail};
        end else begin
            n_lead_valid = w_lead_valid;
            n_lead_word  = w_lead_word;
            n_lead_lane  = w_lead_lane;
            n_lead_pos   = w_lead_pos;
            n_lead_exp   = w_lead_exp;
            w_tail_sum   = (LIDX_W+1)'(w_tail) + (LIDX_W+1)'(w_merge.tail);
        end
        n_tail  = (w_tail_sum > (LIDX_W+1)'(TAIL_SAT)) ? TAIL_SAT : w_tail_sum[TAIL_W-1:0];
        n_chars = w_chars + COUNT_W'(w_merge.nchar);

        // trim an incomplete sequence after a cut by the limit
        w_trim = w_merge.stop && w_merge.cut && r_utf8_mode && n_lead_valid
                 && ({1'b0, n_lead_exp} != n_tail);

        w_lead_hot = '0;
        w_lead_hot[n_lead_lane[LIDX_W-2:0]] = 1'b1;
        w_bytes = w_base + POS_W'(w_merge.stop_lane);
        w_keep  = w_merge.keep;
        if (w_trim) begin
            n_chars = n_chars - COUNT_W'(1);
            w_bytes = n_lead_pos;
            if (w_merge.lead_any) begin
                w_keep = w_merge.keep & ~w_lead_hot;
            end
        end

        for (int k = 0; k < BE_W; k++) begin
            w_data[8*k +: 8] = w_keep[k] ? i_source_word[8*k +: 8] : 8'h00;
        end

        w_item.idx    = w_word_pos[INDEX_W-1:0];
        w_item.data   = w_data;
        w_item.be     = w_merge.be;
        w_item.done   = w_merge.stop;
        w_item.bytes  = w_merge.stop ? w_bytes[COUNT_W-1:0] : '0;
        w_item.chars  = w_merge.stop ? n_chars : '0;
        w_item.second = w_trim && !w_merge.lead_any;
        w_item.idx2   = n_lead_word[INDEX_W-1:0];
        w_item.be2    = w_lead_hot;

        if (w_merge.stop) begin
            n_word_pos = w_word_pos;
            n_base     = w_base;
            n_finished = 1'b1;
        end else begin
            n_word_pos = w_word_pos + POS_W'(1);
            n_base     = w_base + LANE_STEP;
            n_finished = 1'b0;
        end

        // without a push (no accepted beat, or a beat after the end) everything stays as it was
        if (!w_push) begin
            n_word_pos   = r_word_pos;
            n_base       = r_base;
            n_chars      = r_chars;
            n_lead_pos   = r_lead_pos;
            n_lead_word  = r_lead_word;
            n_lead_lane  = r_lead_lane;
            n_lead_exp   = r_lead_exp;
            n_tail       = r_tail;
            n_lead_valid = r_lead_valid;
            n_finished   = r_finished;
        end
    end

    // string state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_pos   <= '0;
            r_base       <= '0;
            r_chars      <= '0;
            r_lead_pos   <= '0;
            r_lead_word  <= '0;
            r_lead_lane  <= '0;
            r_lead_exp   <= '0;
            r_tail       <= '0;
            r_lead_valid <= 1'b0;
            r_finished   <= 1'b0;
        end else begin
            r_word_pos   <= n_word_pos;
            r_base       <= n_base;
            r_chars      <= n_chars;
            r_lead_pos   <= n_lead_pos;
            r_lead_word  <= n_lead_word;
            r_lead_lane  <= n_lead_lane;
            r_lead_exp   <= n_lead_exp;
            r_tail       <= n_tail;
            r_lead_valid <= n_lead_valid;
            r_finished   <= n_finished;
        end
    end

    // result queue
    bsc_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_push),
        .i_item        (w_item),
        .o_full        (w_full),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_word_index  (o_word_index),
        .o_word_data   (o_word_data),
        .o_byte_enable (o_byte_enable),
        .o_copy_done   (o_copy_done),
        .o_byte_count  (o_byte_count),
        .o_char_count  (o_char_count),
        .o_last        (o_last)
    );

endmodule
